/* rtl/vibration_window_classifier_unit_defines.svh */
// Assertion macros shared by the classifier checker
`ifndef VIBRATION_WINDOW_CLASSIFIER_UNIT_DEFINES_SVH
`define VIBRATION_WINDOW_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high
`define VWC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high
`define VWC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/vwc_pkg.sv */
// Types and constants of the vibration window classifier
package vwc_pkg;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 24;
   localparam int THRESH_W    = 24;
   localparam int GRAVITY_W   = 15;
   localparam int ACCEL_W     = 16;
   localparam int CLASS_W     = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_VIBRATION_HIGH = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VIBRATION_LOW  = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRAVITY_REF    = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TILT_TOLERANCE = 8'd3;

   localparam logic [THRESH_W-1:0]  RESET_VIBRATION_HIGH = 24'd32768;
   localparam logic [THRESH_W-1:0]  RESET_VIBRATION_LOW  = 24'd6554;
   localparam logic [GRAVITY_W-1:0] RESET_GRAVITY_REF    = 15'd2511;
   localparam logic [GRAVITY_W-1:0] RESET_TILT_TOLERANCE = 15'd256;

   typedef enum logic [CLASS_W-1:0] {
      CLASS_UNKNOWN  = 3'd0,
      CLASS_ROUGH    = 3'd1,
      CLASS_STEEP    = 3'd2,
      CLASS_SLIPPERY = 3'd3,
      CLASS_FLAT     = 3'd4
   } terrain_class_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ACCUM,
      ST_PRODUCT,
      ST_COMBINE,
      ST_TOTAL,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic signed [ACCEL_W-1:0] accel_x;
      logic signed [ACCEL_W-1:0] accel_y;
      logic signed [ACCEL_W-1:0] accel_z;
   } req_payload_type;

   typedef struct packed {
      logic [CLASS_W-1:0] terrain_class;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [CSR_DATA_W-1:0]  write_data;
   } csr_payload_type;

   typedef struct packed {
      logic [THRESH_W-1:0]  vibration_high;
      logic [THRESH_W-1:0]  vibration_low;
      logic [GRAVITY_W-1:0] gravity_ref;
      logic [GRAVITY_W-1:0] tilt_tolerance;
   } cfg_type;

   // One step of the item sequence per flag
   typedef struct packed {
      logic capture;
      logic square;
      logic accum;
      logic product;
      logic combine;
      logic total;
      logic load_result;
   } cmd_type;

endpackage

/* rtl/vwc_chan_if.sv */
// Valid/ready channel interface carrying one payload beat
interface vwc_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/vwc_csr.sv */
// Configuration register file of the classifier
module vwc_csr (
   input  logic                clock,
   input  logic                reset,
   vwc_chan_if.sink            csr_chan,
   output vwc_pkg::cfg_type    cfg
);

   vwc_pkg::cfg_type cfg_ff;
   vwc_pkg::cfg_type cfg_in;
   logic             write_beat;

   assign csr_chan.ready = 1'b1;
   assign write_beat     = csr_chan.valid && csr_chan.ready;
   assign cfg            = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_beat) begin
         case (csr_chan.payload.reg_index)
            vwc_pkg::CSR_VIBRATION_HIGH: begin
               cfg_in.vibration_high = csr_chan.payload.write_data;
            end
            vwc_pkg::CSR_VIBRATION_LOW: begin
               cfg_in.vibration_low = csr_chan.payload.write_data;
            end
            vwc_pkg::CSR_GRAVITY_REF: begin
               cfg_in.gravity_ref = csr_chan.payload.write_data[vwc_pkg::GRAVITY_W-1:0];
            end
            vwc_pkg::CSR_TILT_TOLERANCE: begin
               cfg_in.tilt_tolerance = csr_chan.payload.write_data[vwc_pkg::GRAVITY_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vibration_high <= vwc_pkg::RESET_VIBRATION_HIGH;
         cfg_ff.vibration_low  <= vwc_pkg::RESET_VIBRATION_LOW;
         cfg_ff.gravity_ref    <= vwc_pkg::RESET_GRAVITY_REF;
         cfg_ff.tilt_tolerance <= vwc_pkg::RESET_TILT_TOLERANCE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/vwc_ctrl.sv */
// Sequencer that steps one sample through the datapath
module vwc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              rsp_ready,
   output logic              req_ready,
   output logic              rsp_valid,
   output vwc_pkg::cmd_type  cmd
);

   vwc_pkg::state_type state_ff;
   vwc_pkg::state_type state_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               out_free;

   // Output register can take a result when empty or being drained
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vwc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = vwc_pkg::ST_SQUARE;
            end
         end
         vwc_pkg::ST_SQUARE:  state_in = vwc_pkg::ST_ACCUM;
         vwc_pkg::ST_ACCUM:   state_in = vwc_pkg::ST_PRODUCT;
         vwc_pkg::ST_PRODUCT: state_in = vwc_pkg::ST_COMBINE;
         vwc_pkg::ST_COMBINE: state_in = vwc_pkg::ST_TOTAL;
         vwc_pkg::ST_TOTAL:   state_in = vwc_pkg::ST_DECIDE;
         vwc_pkg::ST_DECIDE: begin
            if (out_free) begin
               state_in = vwc_pkg::ST_IDLE;
            end
         end
         default: state_in = vwc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         vwc_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         vwc_pkg::ST_SQUARE:  cmd.square  = 1'b1;
         vwc_pkg::ST_ACCUM:   cmd.accum   = 1'b1;
         vwc_pkg::ST_PRODUCT: cmd.product = 1'b1;
         vwc_pkg::ST_COMBINE: cmd.combine = 1'b1;
         vwc_pkg::ST_TOTAL:   cmd.total   = 1'b1;
         vwc_pkg::ST_DECIDE:  cmd.load_result = out_free;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vwc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/vwc_datapath.sv */
// Window memory, running sums, variance products and class decision
module vwc_datapath #(
   parameter int WINDOW_LEN = 50,
   parameter int MIN_FILL   = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  vwc_pkg::cmd_type         cmd,
   input  vwc_pkg::req_payload_type sample,
   input  vwc_pkg::cfg_type         cfg,
   output logic [vwc_pkg::CLASS_W-1:0] terrain_class
);

   localparam int AW     = vwc_pkg::ACCEL_W;
   localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
   localparam int LOG_W  = $clog2(WINDOW_LEN);
   localparam int SUM_W  = AW + LOG_W;
   localparam int PSQ_W  = 2 * AW - 1;
   localparam int SQ_W   = PSQ_W + LOG_W;
   localparam int NQ_W   = SQ_W + CNT_W;
   localparam int S2_W   = 2 * SUM_W - 1;
   localparam int V_W    = NQ_W + 2;
   localparam int NSQ_W  = 2 * CNT_W;
   localparam int THR_W  = vwc_pkg::THRESH_W + NSQ_W;
   localparam int CMP_W  = (V_W > THR_W) ? V_W : THR_W;
   localparam int DZ_W   = AW + 1;

   logic [3*AW-1:0]         win_mem [WINDOW_LEN];
   logic [3*AW-1:0]         old_word_ff;

   logic signed [AW-1:0]    samp_ff   [3];
   logic signed [AW-1:0]    old_samp  [3];
   logic signed [2*AW-1:0]  prod_new  [3];
   logic signed [2*AW-1:0]  prod_old  [3];
   logic [PSQ_W-1:0]        sq_new_ff [3];
   logic [PSQ_W-1:0]        sq_old_ff [3];

   logic signed [SUM_W-1:0] sum_ff    [3];
   logic signed [SUM_W-1:0] sum_in    [3];
   logic [SQ_W-1:0]         sumsq_ff  [3];
   logic [SQ_W-1:0]         sumsq_in  [3];
   logic [CNT_W-1:0]        fill_ff;
   logic [CNT_W-1:0]        fill_in;
   logic [SLOT_W-1:0]       slot_ff;
   logic [SLOT_W-1:0]       slot_in;
   logic                    full;

   logic signed [2*SUM_W-1:0] s2_full [3];
   logic [NQ_W-1:0]         nq_ff     [3];
   logic [S2_W-1:0]         s2_ff     [3];
   logic [NSQ_W-1:0]        nsq_ff;
   logic [NQ_W-1:0]         diff_ff   [3];
   logic [THR_W-1:0]        hi_ff;
   logic [THR_W-1:0]        lo_ff;
   logic [V_W-1:0]          v_ff;
   logic                    tilt_ff;

   logic signed [DZ_W-1:0]  dz_diff;
   logic [DZ_W-1:0]         dz_abs;
   logic                    warm_up;
   logic                    over_high;
   logic                    under_low;
   vwc_pkg::terrain_class_type class_ff;
   vwc_pkg::terrain_class_type class_in;

   assign full = (fill_ff == CNT_W'(WINDOW_LEN));
   assign terrain_class = class_ff;

   assign old_samp[0] = old_word_ff[AW-1:0];
   assign old_samp[1] = old_word_ff[2*AW-1:AW];
   assign old_samp[2] = old_word_ff[3*AW-1:2*AW];

   // Window memory: read the slot on capture, overwrite it in the square step that follows
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         old_word_ff <= win_mem[slot_ff];
      end
      if (cmd.square) begin
         win_mem[slot_ff] <= {samp_ff[2], samp_ff[1], samp_ff[0]};
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod_new[i] = samp_ff[i] * samp_ff[i];
         prod_old[i] = old_samp[i] * old_samp[i];
         s2_full[i]  = sum_ff[i] * sum_ff[i];
      end
   end

   // Slide: drop the oldest sample once the window is full
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (full) begin
            sum_in[i]   = sum_ff[i] + SUM_W'(samp_ff[i]) - SUM_W'(old_samp[i]);
            sumsq_in[i] = sumsq_ff[i] + SQ_W'(sq_new_ff[i]) - SQ_W'(sq_old_ff[i]);
         end else begin
            sum_in[i]   = sum_ff[i] + SUM_W'(samp_ff[i]);
            sumsq_in[i] = sumsq_ff[i] + SQ_W'(sq_new_ff[i]);
         end
      end
      fill_in = full ? fill_ff : fill_ff + CNT_W'(1);
      slot_in = (slot_ff == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_ff + SLOT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         slot_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            sum_ff[i]   <= '0;
            sumsq_ff[i] <= '0;
         end
      end else if (cmd.accum) begin
         fill_ff <= fill_in;
         slot_ff <= slot_in;
         for (int i = 0; i < 3; i++) begin
            sum_ff[i]   <= sum_in[i];
            sumsq_ff[i] <= sumsq_in[i];
         end
      end
   end

   // Per-sample pipeline registers, no reset
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         samp_ff[0] <= sample.accel_x;
         samp_ff[1] <= sample.accel_y;
         samp_ff[2] <= sample.accel_z;
      end
      if (cmd.square) begin
         for (int i = 0; i < 3; i++) begin
            sq_new_ff[i] <= prod_new[i][PSQ_W-1:0];
            sq_old_ff[i] <= prod_old[i][PSQ_W-1:0];
         end
      end
      if (cmd.product) begin
         for (int i = 0; i < 3; i++) begin
            nq_ff[i] <= NQ_W'(fill_ff) * NQ_W'(sumsq_ff[i]);
            s2_ff[i] <= s2_full[i][S2_W-1:0];
         end
         nsq_ff <= NSQ_W'(fill_ff) * NSQ_W'(fill_ff);
      end
      if (cmd.combine) begin
         for (int i = 0; i < 3; i++) begin
            diff_ff[i] <= (nq_ff[i] >= NQ_W'(s2_ff[i])) ? nq_ff[i] - NQ_W'(s2_ff[i]) : '0;
         end
         hi_ff <= THR_W'(cfg.vibration_high) * THR_W'(nsq_ff);
         lo_ff <= THR_W'(cfg.vibration_low) * THR_W'(nsq_ff);
      end
      if (cmd.total) begin
         v_ff    <= V_W'(diff_ff[0]) + V_W'(diff_ff[1]) + V_W'(diff_ff[2]);
         tilt_ff <= dz_abs > DZ_W'(cfg.tilt_tolerance);
      end
   end

   always_comb begin
      dz_diff = DZ_W'(samp_ff[2]) - $signed(DZ_W'(cfg.gravity_ref));
      dz_abs  = dz_diff[DZ_W-1] ? DZ_W'(-dz_diff) : DZ_W'(dz_diff);
   end

   always_comb begin
      warm_up   = 32'(fill_ff) < 32'(MIN_FILL);
      over_high = CMP_W'(v_ff) > CMP_W'(hi_ff);
      under_low = CMP_W'(v_ff) < CMP_W'(lo_ff);
      if (warm_up) begin
         class_in = vwc_pkg::CLASS_UNKNOWN;
      end else if (over_high) begin
         class_in = vwc_pkg::CLASS_ROUGH;
      end else if (tilt_ff) begin
         class_in = vwc_pkg::CLASS_STEEP;
      end else if (under_low) begin
         class_in = vwc_pkg::CLASS_SLIPPERY;
      end else begin
         class_in = vwc_pkg::CLASS_FLAT;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         class_ff <= class_in;
      end
   end

endmodule

/* rtl/vibration_window_classifier_unit.sv */
// A sample's class shows on rsp once the decide step loads the output register.
// A new sample is taken only after the last one is through the fixed step sequence of the
//   controller (capture, square, slide, product, combine, total, decide).
// A waiting result does not block the next sample until that sample's decide step.
// Reset clears the fill count, write slot and running sums and sets the configuration registers to defaults;
//   the window memory is not cleared, a slot's old value is used only after it was written.
module vibration_window_classifier_unit #(
   parameter int WINDOW_LEN = 50,
   parameter int MIN_FILL   = 10
) (
   input  logic        clock,
   input  logic        reset,
   vwc_chan_if.sink    req_chan,
   vwc_chan_if.source  rsp_chan,
   vwc_chan_if.sink    csr_chan
);

   vwc_pkg::cmd_type            cmd;
   vwc_pkg::cfg_type            cfg;
   vwc_pkg::req_payload_type    sample;
   logic                        req_ready;
   logic                        rsp_valid;
   logic [vwc_pkg::CLASS_W-1:0] terrain_class;

   // Configuration registers; writes are taken every cycle
   vwc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // Sequencer: ready only while idle, holds the result valid flag
   vwc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   assign sample = req_chan.payload;

   // Datapath: window memory, sums, variance products and the output register
   vwc_datapath #(
      .WINDOW_LEN (WINDOW_LEN),
      .MIN_FILL   (MIN_FILL)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sample        (sample),
      .cfg           (cfg),
      .terrain_class (terrain_class)
   );

   // Drive the channel beats
   assign req_chan.ready                 = req_ready;
   assign rsp_chan.valid                 = rsp_valid;
   assign rsp_chan.payload.terrain_class = terrain_class;

endmodule

/* rtl/vwc_checker.sv */
// Port-level checks of the classifier, bound to the top level
`include "vibration_window_classifier_unit_defines.svh"

module vwc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   logic       req_beat;
   logic       rsp_beat;
   logic [6:0] req_dly_ff;
   logic [1:0] pending_ff;
   logic [1:0] pending_in;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_beat && !rsp_beat) begin
         pending_in = pending_ff + 2'd1;
      end else if (rsp_beat && !req_beat) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_dly_ff <= '0;
         pending_ff <= '0;
      end else begin
         req_dly_ff <= {req_dly_ff[5:0], req_beat};
         pending_ff <= pending_in;
      end
   end

   `VWC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp beat dropped")
   `VWC_ASSERT_NEXT(a_one_in_flight, req_beat, !req_ready, "req taken twice in a row")
   `VWC_ASSERT_SAME(a_rsp_latency, $rose(rsp_valid), req_dly_ff[6], "rsp not 7 cycles after req")
   `VWC_ASSERT_SAME(a_rsp_has_req, rsp_valid, pending_ff != 2'd0, "rsp without a req beat")
   `VWC_ASSERT_SAME(a_pending_max, 1'b1, pending_ff != 2'd3, "more than two samples open")

endmodule

bind vibration_window_classifier_unit vwc_checker u_vwc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready)
);
